>>> hdl/hrbs_pkg.sv
// Shared types and constants for the RGB hue-rotate / brightness-scale block.
// No dependencies.
package hrbs_pkg;

  localparam int PIX_W     = 8;
  localparam int COEFF_W   = 16;
  localparam int COUNT_W   = 32;
  localparam int REWRITE_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_STAGES = 6;

  localparam int S_TDATA_W = 56;  // 3*8 + 32 = 56, already whole bytes
  localparam int M_TDATA_W = 40;  // 3*8 + 1 + 10 = 35, padded to 40

  // Brightness thresholds on count >> 2.
  localparam logic [29:0] ROLLOVER_LIMIT = 30'd510;
  localparam logic [29:0] OVERFLOW_LIMIT = 30'd255;
  localparam logic [7:0]  BRIGHT_MAX     = 8'd255;
  localparam logic [REWRITE_W-1:0] REWRITE_OVERFLOW = 10'd1020;
  localparam logic [REWRITE_W-1:0] REWRITE_ROLLOVER = 10'd0;

  localparam logic signed [COEFF_W-1:0] COEFF_DIAG_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_DIAG   = 2'd0,
    REG_COEFF_AFTER  = 2'd1,
    REG_COEFF_BEFORE = 2'd2
  } cfg_reg_t;

  // Per-stage load enables, from pipeline control to the lanes.
  typedef struct packed {
    logic mul;
    logic sum;
    logic scale;
    logic split;
    logic recip;
    logic out;
  } stage_en_t;

  typedef struct packed {
    logic                 rewrite;
    logic [REWRITE_W-1:0] value;
  } rewrite_t;

endpackage

>>> hdl/hrbs_ctrl.sv
// Valid/advance control for the six-stage pixel pipeline.
// Depends on hrbs_pkg.
module hrbs_ctrl
  import hrbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_en_t en
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] adv;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign en.mul   = adv[0];
  assign en.sum   = adv[1];
  assign en.scale = adv[2];
  assign en.split = adv[3];
  assign en.recip = adv[4];
  assign en.out   = adv[5];

  assign in_ready  = adv[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

>>> hdl/hrbs_lane.sv
// One color lane: matrix row, brightness scale, divide by full scale, clip.
// Depends on hrbs_pkg; stage enables come from hrbs_ctrl.
module hrbs_lane
  import hrbs_pkg::*;
#(
  parameter int FULL_SCALE_BRIGHTNESS = 255
) (
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic signed [COEFF_W-1:0] coeff_r,
  input  logic signed [COEFF_W-1:0] coeff_g,
  input  logic signed [COEFF_W-1:0] coeff_b,
  input  logic [PIX_W-1:0]          pix_r,
  input  logic [PIX_W-1:0]          pix_g,
  input  logic [PIX_W-1:0]          pix_b,
  input  logic [PIX_W-1:0]          bright,
  output logic [PIX_W-1:0]          result
);

  // floor(T / F) == (T * RECIP) >> 24 exactly for T < 2^16.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + FULL_SCALE_BRIGHTNESS - 1)
                               / FULL_SCALE_BRIGHTNESS;
  localparam int CLIP_LIMIT  = 256 * 16384 * FULL_SCALE_BRIGHTNESS;

  localparam logic [24:0]        RECIP_W = 25'(RECIP);
  localparam logic signed [35:0] CLIP_W  = 36'(CLIP_LIMIT);

  logic signed [24:0] prod_r, prod_g, prod_b;
  logic signed [26:0] row_sum;
  logic signed [35:0] scaled;
  logic [15:0]        quot_in;
  logic               neg3, nz3, over3;
  logic [40:0]        recip_prod;
  logic               neg4, nz4, over4;
  logic [PIX_W-1:0]   quot;
  logic [PIX_W-1:0]   clipped;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= coeff_r * $signed({1'b0, pix_r});
      prod_g <= coeff_g * $signed({1'b0, pix_g});
      prod_b <= coeff_b * $signed({1'b0, pix_b});
    end
    if (en.sum) begin
      row_sum <= 27'(prod_r) + 27'(prod_g) + 27'(prod_b);
    end
    if (en.scale) begin
      scaled <= row_sum * $signed({1'b0, bright});
    end
    if (en.split) begin
      neg3    <= scaled[35];
      nz3     <= (scaled != '0);
      over3   <= (scaled >= CLIP_W);
      quot_in <= scaled[29:14];
    end
    if (en.recip) begin
      recip_prod <= 41'(quot_in) * 41'(RECIP_W);
      neg4       <= neg3;
      nz4        <= nz3;
      over4      <= over3;
    end
    if (en.out) begin
      result <= clipped;
    end
  end

  assign quot = recip_prod[RECIP_SHIFT +: PIX_W];

  // Clip, then keep a nonzero product visible as at least 1.
  always_comb begin
    if (over4) begin
      clipped = '1;
    end else if (neg4) begin
      clipped = '0;
    end else begin
      clipped = quot;
    end
    if (nz4 && clipped == '0) begin
      clipped = 8'd1;
    end
  end

endmodule

>>> hdl/rgb_hue_rotate_brightness_scale.sv
// Top level: RGB hue rotation through a circulant Q2.14 matrix with brightness scaling.
// Depends on hrbs_pkg, hrbs_ctrl and hrbs_lane.
//
//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | s_tdata: red_in, green_in, blue_in, brightness_count
//  m_*     | out       | m_tdata: red_out, green_out, blue_out, count_rewrite,
//          |           |          count_rewrite_value
//  cfg_*   | in        | cfg_index selects coefficient, cfg_data is the value
//
// The six-stage lane pipeline (products, row sum, brightness product, split,
// reciprocal product, clip) accepts one pixel per cycle unless the output
// stalls. Stages advance independently, so input stays ready while any stage
// holds a bubble, even with a result waiting on the output. Reset empties the
// pipeline and restores the identity matrix.
module rgb_hue_rotate_brightness_scale
  import hrbs_pkg::*;
#(
  parameter int FULL_SCALE_BRIGHTNESS = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  // {brightness_count[55:24], blue_in[23:16], green_in[15:8], red_in[7:0]}
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // {pad[39:35], count_rewrite_value[34:25], count_rewrite[24],
  //  blue_out[23:16], green_out[15:8], red_out[7:0]}
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data
);

  // Coefficient registers (D, A, B).
  logic signed [COEFF_W-1:0] coeff_diagonal;
  logic signed [COEFF_W-1:0] coeff_after_diagonal;
  logic signed [COEFF_W-1:0] coeff_before_diagonal;

  stage_en_t en;

  logic [PIX_W-1:0]   red_in, green_in, blue_in;
  logic [COUNT_W-1:0] brightness_count;
  logic [29:0]        shadow;

  logic [PIX_W-1:0] bright_next, bright0, bright1;
  rewrite_t         rw_next, rw0, rw1, rw2, rw3, rw4, rw5;

  logic [PIX_W-1:0] red_out, green_out, blue_out;

  assign red_in           = s_tdata[7:0];
  assign green_in         = s_tdata[15:8];
  assign blue_in          = s_tdata[23:16];
  assign brightness_count = s_tdata[55:24];

  // Config writes: always ready, indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_diagonal        <= COEFF_DIAG_RESET;
      coeff_after_diagonal  <= '0;
      coeff_before_diagonal <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEFF_DIAG:   coeff_diagonal        <= cfg_data;
        REG_COEFF_AFTER:  coeff_after_diagonal  <= cfg_data;
        REG_COEFF_BEFORE: coeff_before_diagonal <= cfg_data;
        default: ;
      endcase
    end
  end

  // Brightness decode: rollover above 510, saturate above 255.
  assign shadow = brightness_count[COUNT_W-1:2];

  always_comb begin
    priority if (shadow > ROLLOVER_LIMIT) begin
      bright_next   = '0;
      rw_next.rewrite = 1'b1;
      rw_next.value   = REWRITE_ROLLOVER;
    end else if (shadow > OVERFLOW_LIMIT) begin
      bright_next   = BRIGHT_MAX;
      rw_next.rewrite = 1'b1;
      rw_next.value   = REWRITE_OVERFLOW;
    end else begin
      bright_next   = shadow[PIX_W-1:0];
      rw_next.rewrite = 1'b0;
      rw_next.value   = '0;
    end
  end

  // Sideband moves with the lanes, one register per stage; brightness stops at sum.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      bright0 <= bright_next;
      rw0     <= rw_next;
    end
    if (en.sum) begin
      bright1 <= bright0;
      rw1     <= rw0;
    end
    if (en.scale) rw2 <= rw1;
    if (en.split) rw3 <= rw2;
    if (en.recip) rw4 <= rw3;
    if (en.out)   rw5 <= rw4;
  end

  hrbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .en        (en)
  );

  // Rows: red = D A B, green = B D A, blue = A B D.
  hrbs_lane #(.FULL_SCALE_BRIGHTNESS(FULL_SCALE_BRIGHTNESS)) u_lane_red (
    .clk     (clk),
    .en      (en),
    .coeff_r (coeff_diagonal),
    .coeff_g (coeff_after_diagonal),
    .coeff_b (coeff_before_diagonal),
    .pix_r   (red_in),
    .pix_g   (green_in),
    .pix_b   (blue_in),
    .bright  (bright1),
    .result  (red_out)
  );

  hrbs_lane #(.FULL_SCALE_BRIGHTNESS(FULL_SCALE_BRIGHTNESS)) u_lane_green (
    .clk     (clk),
    .en      (en),
    .coeff_r (coeff_before_diagonal),
    .coeff_g (coeff_diagonal),
    .coeff_b (coeff_after_diagonal),
    .pix_r   (red_in),
    .pix_g   (green_in),
    .pix_b   (blue_in),
    .bright  (bright1),
    .result  (green_out)
  );

  hrbs_lane #(.FULL_SCALE_BRIGHTNESS(FULL_SCALE_BRIGHTNESS)) u_lane_blue (
    .clk     (clk),
    .en      (en),
    .coeff_r (coeff_after_diagonal),
    .coeff_g (coeff_before_diagonal),
    .coeff_b (coeff_diagonal),
    .pix_r   (red_in),
    .pix_g   (green_in),
    .pix_b   (blue_in),
    .bright  (bright1),
    .result  (blue_out)
  );

  // Merge the lanes and the rewrite request into one output beat.
  assign m_tdata = {5'd0, rw5.value, rw5.rewrite, blue_out, green_out, red_out};

  // A rewrite value only appears together with the rewrite flag.
  a_rewrite_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:25] == '0 || m_tdata[24]))
    else $error("rewrite value without rewrite flag");

  // An empty output stage means the whole pipeline can advance.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  // Reset restores the identity matrix.
  a_reset_identity: assert property (@(posedge clk)
    rst |=> (coeff_diagonal == COEFF_DIAG_RESET
             && coeff_after_diagonal == '0 && coeff_before_diagonal == '0))
    else $error("coefficients not at identity after reset");

endmodule

>>> tb/hrbs_pixel_checker.sv
`timescale 1ns / 100ps
// Scoreboard for rgb_hue_rotate_brightness_scale: watches the pixel, result and
// coefficient channels, predicts each result beat and compares it field by field.
// Depends on hrbs_pkg.
module hrbs_pixel_checker
  import hrbs_pkg::*;
#(
  parameter int FULL_SCALE_BRIGHTNESS = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data,
  input  logic                 drain_check,   // high once the run is over
  output int                   fail_count,
  output int                   pending,
  output int                   pixels_checked,
  output int                   overflow_seen,
  output int                   rollover_seen,
  output int                   min_light_seen
);

  localparam logic [29:0] ROLL_ABOVE = 30'd510;
  localparam logic [29:0] SAT_ABOVE  = 30'd255;
  localparam logic [9:0]  SAT_COUNT  = 10'd1020;

  // Same bit order as m_tdata, so a beat maps straight onto it.
  typedef struct packed {
    logic [4:0] pad;
    logic [9:0] rewrite_value;
    logic       rewrite;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_result_t;

  logic signed [15:0] coeff_diag;
  logic signed [15:0] coeff_after;
  logic signed [15:0] coeff_before;
  pixel_result_t      result_q[$];
  bit                 swept;

  initial begin
    fail_count     = 0;
    pending        = 0;
    pixels_checked = 0;
    overflow_seen  = 0;
    rollover_seen  = 0;
    min_light_seen = 0;
    swept          = 0;
    coeff_diag     = 16'sd16384;
    coeff_after    = '0;
    coeff_before   = '0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch on beat %0d: %s", $time, pixels_checked, what);
    fail_count++;
  endtask

  // Exact scaling, truncated toward zero, clipped; nonzero light never goes dark.
  function automatic logic [7:0] scale_channel(input longint row_sum, input longint bright,
                                               output bit floored);
    longint     quot;
    logic [7:0] level;
    quot = (row_sum * bright) / (longint'(16384) * FULL_SCALE_BRIGHTNESS);
    floored = 1'b0;
    if (quot < 0)
      level = 8'd0;
    else if (quot > 255)
      level = 8'd255;
    else
      level = quot[7:0];
    if (row_sum != 0 && bright != 0 && level == 8'd0) begin
      level   = 8'd1;
      floored = 1'b1;
    end
    return level;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [S_TDATA_W-1:0] beat,
                                                  output int floors);
    longint        r, g, b, d, a, c, bright;
    logic [29:0]   level;
    bit            f_r, f_g, f_b;
    pixel_result_t res;
    r     = beat[7:0];
    g     = beat[15:8];
    b     = beat[23:16];
    level = beat[55:26];
    d     = coeff_diag;
    a     = coeff_after;
    c     = coeff_before;
    res   = '0;
    if (level > ROLL_ABOVE) begin
      bright            = 0;
      res.rewrite       = 1'b1;
      res.rewrite_value = 10'd0;
    end else if (level > SAT_ABOVE) begin
      bright            = 255;
      res.rewrite       = 1'b1;
      res.rewrite_value = SAT_COUNT;
    end else begin
      bright = level;
    end
    // circulant rows: D on the diagonal, A right of it, B left of it
    res.red   = scale_channel(d * r + a * g + c * b, bright, f_r);
    res.green = scale_channel(c * r + d * g + a * b, bright, f_g);
    res.blue  = scale_channel(a * r + c * g + d * b, bright, f_b);
    floors    = f_r + f_g + f_b;
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    int            floors;
    if (rst) begin
      coeff_diag   = 16'sd16384;
      coeff_after  = '0;
      coeff_before = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEFF_DIAG:   coeff_diag   = cfg_data;
          REG_COEFF_AFTER:  coeff_after  = cfg_data;
          REG_COEFF_BEFORE: coeff_before = cfg_data;
          default: ;  // unmapped index, write dropped
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (result_q.size() == 0) begin
          flag_mismatch("result beat with no pixel outstanding");
        end else begin
          want = result_q.pop_front();
          if (got.red !== want.red)
            flag_mismatch($sformatf("red_out %0d, want %0d", got.red, want.red));
          if (got.green !== want.green)
            flag_mismatch($sformatf("green_out %0d, want %0d", got.green, want.green));
          if (got.blue !== want.blue)
            flag_mismatch($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
          if (got.rewrite !== want.rewrite)
            flag_mismatch($sformatf("count_rewrite %0b, want %0b", got.rewrite, want.rewrite));
          if (got.rewrite_value !== want.rewrite_value)
            flag_mismatch($sformatf("count_rewrite_value %0d, want %0d",
                                    got.rewrite_value, want.rewrite_value));
          if (got.pad !== want.pad)
            flag_mismatch($sformatf("pad bits %b, want zero", got.pad));
          pixels_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_pixel(s_tdata, floors);
        min_light_seen += floors;
        if (want.rewrite && want.rewrite_value == SAT_COUNT)
          overflow_seen++;
        else if (want.rewrite)
          rollover_seen++;
        result_q.push_back(want);
      end
      if (drain_check && !swept) begin
        swept = 1'b1;
        if (result_q.size() != 0)
          flag_mismatch($sformatf("%0d results never arrived", result_q.size()));
      end
    end
    pending = result_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for rgb_hue_rotate_brightness_scale: clock, reset, pixel and
// coefficient stimulus, random back-pressure and the verdict.
// Depends on hrbs_pkg, the block's RTL and hrbs_pixel_checker.
module tb;
  import hrbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
  localparam int PIPE_DRAIN     = 12;       // pipeline is 6 deep; margin on top
  localparam int NUM_SETTINGS   = 8;
  localparam int PIXELS_PER_SET = 225;      // 8 x 225 = 1800 random pixels
  localparam int LIMIT_NS       = 2_000_000;

  typedef struct {
    logic [COEFF_W-1:0] diag;
    logic [COEFF_W-1:0] after;
    logic [COEFF_W-1:0] prior;
  } coeff_set_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_data  = '0;
  logic                 drain_check = 1'b0;

  int fail_count, pending, pixels_checked, overflow_seen, rollover_seen, min_light_seen;

  // Shared by the pixel source and the result sink: when clear, both run flat out.
  bit idle_on = 1'b1;

  coeff_set_t coeff_sets[NUM_SETTINGS];

  always #5 clk = ~clk;

  rgb_hue_rotate_brightness_scale dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hrbs_pixel_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .s_tdata        (s_tdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .m_tdata        (m_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .drain_check    (drain_check),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .overflow_seen  (overflow_seen),
    .rollover_seen  (rollover_seen),
    .min_light_seen (min_light_seen)
  );

  // One pixel beat. Inputs move on the falling edge; a zero gap keeps tvalid
  // high straight into the next beat, so tvalid never drops and rises in one step.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [31:0] count);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {count, b, g, r};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop the source and hold off until every outstanding result is back, then
  // give the pipeline its full depth to settle.
  task automatic drain_pipe();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Only called with the pipeline empty.
  task automatic load_coeffs(input coeff_set_t set);
    write_reg(REG_COEFF_DIAG, set.diag);
    write_reg(REG_COEFF_AFTER, set.after);
    write_reg(REG_COEFF_BEFORE, set.prior);
    // now and then poke the unmapped index; the block must drop it
    if ($urandom_range(0, 1) == 0)
      write_reg(REG_SPARE, 16'($urandom));
  endtask

  // Channels lean toward the ends of the range and toward tiny values,
  // which is where the minimum-light floor kicks in.
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [31:0] count;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: count = $urandom_range(0, 1023);      // normal brightness
      6:                count = $urandom_range(1024, 2043);   // overflow band
      7:                count = $urandom_range(0, 15);        // very dim
      8:                count = $urandom;                     // mostly rollover, all bits
      default:          count = $urandom_range(2040, 2050);   // overflow/rollover edge
    endcase
    send_pixel(rand_channel(), rand_channel(), rand_channel(), count);
  endtask

  // Result sink: a fresh random stall before each result beat.
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    #LIMIT_NS;
    $display("[rgb_hue_rotate_brightness_scale] ERROR");
    $finish;
  end

  initial begin
    coeff_set_t mixed;
    // Settings for the random part: identity, both signed extremes, all zero,
    // a pure channel permutation, a 60 degree hue turn, and two random sets.
    coeff_sets[0] = '{16'sd16384, 16'sd0, 16'sd0};
    coeff_sets[1] = '{16'sh8000, 16'sh8000, 16'sh8000};
    coeff_sets[2] = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    coeff_sets[3] = '{16'sd0, 16'sd0, 16'sd0};
    coeff_sets[4] = '{16'sd0, 16'sd16384, 16'sd0};
    coeff_sets[5] = '{16'sd10923, -16'sd5461, 16'sd10923};
    coeff_sets[6] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    coeff_sets[7] = '{16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset coefficients (identity): brightness thresholds and
    // the minimum-light floor.
    send_pixel(8'd0, 8'd0, 8'd0, 32'd0);              // all zero
    send_pixel(8'd255, 8'd255, 8'd255, 32'd1020);     // full white, full scale
    send_pixel(8'd255, 8'd0, 8'd0, 32'd1023);         // top of normal band
    send_pixel(8'd0, 8'd255, 8'd0, 32'd1024);         // first overflow count
    send_pixel(8'd0, 8'd0, 8'd255, 32'd2043);         // last overflow count
    send_pixel(8'd255, 8'd255, 8'd255, 32'd2044);     // first rollover count
    send_pixel(8'd128, 8'd64, 8'd32, 32'hffff_ffff);  // counter at its maximum
    send_pixel(8'd1, 8'd1, 8'd1, 32'd4);              // floor lifts 0 to 1
    send_pixel(8'd1, 8'd2, 8'd3, 32'd3);              // zero brightness, no floor
    send_pixel(8'd255, 8'd255, 8'd255, 32'd4);        // brightness 1
    send_pixel(8'd200, 8'd100, 8'd50, 32'd512);       // half brightness

    // Negative and saturating row sums.
    drain_pipe();
    mixed = '{16'sh8000, 16'sh7fff, 16'sd0};
    load_coeffs(mixed);
    send_pixel(8'd255, 8'd0, 8'd0, 32'd1020);
    send_pixel(8'd0, 8'd255, 8'd0, 32'd1020);
    send_pixel(8'd0, 8'd0, 8'd255, 32'd1020);
    send_pixel(8'd255, 8'd255, 8'd255, 32'd1020);
    send_pixel(8'd0, 8'd0, 8'd0, 32'd1020);
    send_pixel(8'd255, 8'd255, 8'd255, 32'd0);
    send_pixel(8'd17, 8'd255, 8'd3, 32'd2044);

    // A write to the unmapped index must leave the matrix alone.
    drain_pipe();
    write_reg(REG_SPARE, 16'hffff);
    send_pixel(8'd255, 8'd0, 8'd0, 32'd1020);

    for (int set = 0; set < NUM_SETTINGS; set++) begin
      drain_pipe();
      load_coeffs(coeff_sets[set]);
      idle_on = (set % 3 != 2);
      for (int item = 0; item < PIXELS_PER_SET; item++) begin
        send_random_pixel();
        // one mid-stream pause with no register write behind it
        if (set == 1 && item == PIXELS_PER_SET / 2)
          drain_pipe();
      end
    end

    drain_pipe();
    @(negedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Checked %0d pixel beats across %0d coefficient settings plus directed cases;",
             pixels_checked, NUM_SETTINGS);
    $display("  %0d overflow and %0d rollover counts, %0d channels held at minimum light.",
             overflow_seen, rollover_seen, min_light_seen);
    if (fail_count == 0)
      $display("[rgb_hue_rotate_brightness_scale] OK");
    else
      $display("[rgb_hue_rotate_brightness_scale] ERROR");
    $finish;
  end

endmodule
